[rtl/lbps_pkg.sv]
// Shared constants, register types and codes of the lamp blink pattern sequencer.
`timescale 1ns / 1ps

package lbps_pkg;

  // Width of the elapsed time accumulator (16 to 32).
  localparam int TimeBits = 24;
  // Width of the configured time registers.
  localparam int CfgTimeBits = 24;
  // Width used to compare elapsed time with a configured time.
  localparam int CmpBits = (TimeBits > CfgTimeBits) ? TimeBits : CfgTimeBits;

  localparam int ModeBits = 3;
  localparam int PhaseBits = 3;
  localparam int StepBits = 16;

  // Lamp modes.
  localparam logic [ModeBits-1:0] ModeOff     = 3'd0;
  localparam logic [ModeBits-1:0] ModeReverse = 3'd1;
  localparam logic [ModeBits-1:0] ModeLeft    = 3'd2;
  localparam logic [ModeBits-1:0] ModeRight   = 3'd3;
  localparam logic [ModeBits-1:0] ModeHazard  = 3'd4;

  // Hazard phases.
  localparam logic [PhaseBits-1:0] PhaseShortOnA  = 3'd0;
  localparam logic [PhaseBits-1:0] PhaseShortOffA = 3'd1;
  localparam logic [PhaseBits-1:0] PhaseShortOnB  = 3'd2;
  localparam logic [PhaseBits-1:0] PhaseShortOffB = 3'd3;
  localparam logic [PhaseBits-1:0] PhaseLongOn    = 3'd4;
  localparam logic [PhaseBits-1:0] PhaseLongOff   = 3'd5;

  // Register indexes (byte address divided by four).
  localparam int RegIdxBits = 3;
  localparam int AddrBits = 5;
  localparam logic [RegIdxBits-1:0] RegLampMode   = 3'd0;
  localparam logic [RegIdxBits-1:0] RegBlinkHalf  = 3'd1;
  localparam logic [RegIdxBits-1:0] RegShortOn    = 3'd2;
  localparam logic [RegIdxBits-1:0] RegShortOff   = 3'd3;
  localparam logic [RegIdxBits-1:0] RegLongOn     = 3'd4;
  localparam logic [RegIdxBits-1:0] RegLongOff    = 3'd5;

  // Reset values.
  localparam logic [CfgTimeBits-1:0] BlinkHalfRst = 24'd333333;
  localparam logic [CfgTimeBits-1:0] ShortOnRst   = 24'd100000;
  localparam logic [CfgTimeBits-1:0] ShortOffRst  = 24'd100000;
  localparam logic [CfgTimeBits-1:0] LongOnRst    = 24'd300000;
  localparam logic [CfgTimeBits-1:0] LongOffRst   = 24'd400000;

  typedef struct packed {
    logic [ModeBits-1:0]    lamp_mode;
    logic [CfgTimeBits-1:0] blink_half_period;
    logic [CfgTimeBits-1:0] short_on_time;
    logic [CfgTimeBits-1:0] short_off_time;
    logic [CfgTimeBits-1:0] long_on_time;
    logic [CfgTimeBits-1:0] long_off_time;
  } cfg_t;

endpackage

[rtl/lbps_regs.sv]
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module lbps_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lbps_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output lbps_pkg::cfg_t               cfg_o,
  output logic                         mode_wr_o
);

  lbps_pkg::cfg_t                     cfg_q, cfg_d;
  logic                               wr_en;
  logic [lbps_pkg::RegIdxBits-1:0]    idx;
  logic [lbps_pkg::CfgTimeBits-1:0]   wdata_time;

  assign pready     = 1'b1;
  assign idx        = paddr[lbps_pkg::AddrBits-1:2];
  assign wr_en      = psel && penable && pwrite;
  assign wdata_time = pwdata[lbps_pkg::CfgTimeBits-1:0];
  assign mode_wr_o  = wr_en && (idx == lbps_pkg::RegLampMode);
  assign cfg_o      = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        lbps_pkg::RegLampMode:  cfg_d.lamp_mode = pwdata[lbps_pkg::ModeBits-1:0];
        lbps_pkg::RegBlinkHalf: cfg_d.blink_half_period = wdata_time;
        lbps_pkg::RegShortOn:   cfg_d.short_on_time = wdata_time;
        lbps_pkg::RegShortOff:  cfg_d.short_off_time = wdata_time;
        lbps_pkg::RegLongOn:    cfg_d.long_on_time = wdata_time;
        lbps_pkg::RegLongOff:   cfg_d.long_off_time = wdata_time;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lbps_pkg::RegLampMode:  prdata = 32'(cfg_q.lamp_mode);
      lbps_pkg::RegBlinkHalf: prdata = 32'(cfg_q.blink_half_period);
      lbps_pkg::RegShortOn:   prdata = 32'(cfg_q.short_on_time);
      lbps_pkg::RegShortOff:  prdata = 32'(cfg_q.short_off_time);
      lbps_pkg::RegLongOn:    prdata = 32'(cfg_q.long_on_time);
      lbps_pkg::RegLongOff:   prdata = 32'(cfg_q.long_off_time);
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lamp_mode         <= lbps_pkg::ModeOff;
      cfg_q.blink_half_period <= lbps_pkg::BlinkHalfRst;
      cfg_q.short_on_time     <= lbps_pkg::ShortOnRst;
      cfg_q.short_off_time    <= lbps_pkg::ShortOffRst;
      cfg_q.long_on_time      <= lbps_pkg::LongOnRst;
      cfg_q.long_off_time     <= lbps_pkg::LongOffRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/lamp_blink_pattern_sequencer.sv]
// Top level of the lamp blink pattern sequencer: tick datapath and result register.
`timescale 1ns / 1ps

// Each input transfer is a time tick carrying the microseconds since the previous
// tick; each tick produces exactly one result transfer with the left and right lamp
// levels and the current hazard phase. One tick is accepted every clock cycle while the
// output register can take it; the result appears in the output register in the cycle
// after acceptance, set by the single add, compare and phase update between the state
// registers and that register. The input is accepted whenever the output register is
// empty or is being taken in the same cycle. Writing the lamp mode register clears the
// elapsed time, the blink level and the hazard phase; the lamp levels last driven are
// kept. Registers sit at byte addresses 0 (mode), 4 (blink half period), 8 (short on),
// 12 (short off), 16 (long on) and 20 (long off); times are in microseconds.
module lamp_blink_pattern_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB-style configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbps_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Tick input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] time_step
  // Lamp result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata   // [0] left_lamp, [1] right_lamp,
                                                       // [4:2] pattern_phase, [7:5] zero
);

  localparam int TB = lbps_pkg::TimeBits;
  localparam int CB = lbps_pkg::CmpBits;

  lbps_pkg::cfg_t cfg;
  logic           mode_wr;

  lbps_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .mode_wr_o (mode_wr)
  );

  logic [TB-1:0]                    elapsed_q, elapsed_d;
  logic [lbps_pkg::PhaseBits-1:0]   phase_q, phase_d;
  logic                             blink_q, blink_d;
  logic                             left_q, left_d;
  logic                             right_q, right_d;
  logic                             out_valid_q;
  logic [lbps_pkg::PhaseBits-1:0]   out_phase_q;

  logic                             s_acc;
  logic [TB:0]                      sum;
  logic [TB-1:0]                    el_sat;
  logic [CB-1:0]                    el_cmp;
  logic [lbps_pkg::PhaseBits-1:0]   phase_cur;
  logic [lbps_pkg::CfgTimeBits-1:0] phase_time;
  logic                             blink_hit;
  logic                             phase_hit;
  logic                             blink_inv;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign sum    = {1'b0, elapsed_q} + (TB + 1)'(s_axis_tdata);
  assign el_sat = sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
  assign el_cmp = CB'(el_sat);

  // Unreachable phase codes fall back to the first short flash.
  assign phase_cur = (phase_q <= lbps_pkg::PhaseLongOff) ? phase_q : lbps_pkg::PhaseShortOnA;

  always_comb begin
    unique case (phase_cur) inside
      lbps_pkg::PhaseShortOffA,
      lbps_pkg::PhaseShortOffB: phase_time = cfg.short_off_time;
      lbps_pkg::PhaseLongOn:    phase_time = cfg.long_on_time;
      lbps_pkg::PhaseLongOff:   phase_time = cfg.long_off_time;
      default:                  phase_time = cfg.short_on_time;
    endcase
  end

  assign blink_hit = el_cmp >= CB'(cfg.blink_half_period);
  assign phase_hit = el_cmp >= CB'(phase_time);
  assign blink_inv = ~blink_q;

  always_comb begin
    elapsed_d = el_sat;
    phase_d   = phase_q;
    blink_d   = blink_q;
    left_d    = left_q;
    right_d   = right_q;
    unique case (cfg.lamp_mode) inside
      lbps_pkg::ModeReverse: begin
        left_d  = 1'b1;
        right_d = 1'b1;
      end
      lbps_pkg::ModeLeft,
      lbps_pkg::ModeRight: begin
        if (blink_hit) begin
          blink_d   = blink_inv;
          left_d    = (cfg.lamp_mode == lbps_pkg::ModeLeft) && blink_inv;
          right_d   = (cfg.lamp_mode == lbps_pkg::ModeRight) && blink_inv;
          elapsed_d = '0;
        end
      end
      lbps_pkg::ModeHazard: begin
        // Lamps are lit in the even phases.
        left_d  = ~phase_cur[0];
        right_d = ~phase_cur[0];
        if (phase_hit) begin
          phase_d   = (phase_cur == lbps_pkg::PhaseLongOff) ? lbps_pkg::PhaseShortOnA
                                                            : phase_cur + 3'd1;
          elapsed_d = '0;
        end
      end
      default: begin
        left_d  = 1'b0;
        right_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      phase_q   <= lbps_pkg::PhaseShortOnA;
      blink_q   <= 1'b0;
      left_q    <= 1'b0;
      right_q   <= 1'b0;
    end else if (mode_wr) begin
      elapsed_q <= '0;
      phase_q   <= lbps_pkg::PhaseShortOnA;
      blink_q   <= 1'b0;
    end else if (s_acc) begin
      elapsed_q <= elapsed_d;
      phase_q   <= phase_d;
      blink_q   <= blink_d;
      left_q    <= left_d;
      right_q   <= right_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      out_phase_q <= phase_d;
    end
  end

  // The lamp levels of the result are the drive registers themselves.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_phase_q, right_q, left_q};

`ifndef SYNTHESIS
  a_mode_wr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_wr |=> (elapsed_q == '0) && (phase_q == lbps_pkg::PhaseShortOnA) && !blink_q)
    else $error("mode write did not clear the sequencer state");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= lbps_pkg::PhaseLongOff)
    else $error("hazard phase out of range");

  a_reverse_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !mode_wr && (cfg.lamp_mode == lbps_pkg::ModeReverse))
      |=> m_axis_tdata[0] && m_axis_tdata[1])
    else $error("reverse mode did not light both lamps");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !mode_wr && (cfg.lamp_mode == lbps_pkg::ModeOff))
      |=> !m_axis_tdata[0] && !m_axis_tdata[1])
    else $error("off mode did not darken both lamps");

  a_out_phase_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !mode_wr) |=> (m_axis_tdata[4:2] == phase_q))
    else $error("result phase differs from hazard phase");
`endif

endmodule

[sim/tb_top.sv]
// Self-checking bench for the lamp blink pattern sequencer: a directed table, then random ticks.
`timescale 1ns / 1ps

module tb_top;

  typedef logic [lbps_pkg::ModeBits-1:0]    mode_t;
  typedef logic [lbps_pkg::PhaseBits-1:0]   phase_t;
  typedef logic [lbps_pkg::RegIdxBits-1:0]  idx_t;
  typedef logic [lbps_pkg::StepBits-1:0]    step_t;
  typedef logic [lbps_pkg::CfgTimeBits-1:0] cfg_time_t;

  // Mode codes the block treats as off, and register slots that hold nothing.
  localparam mode_t       ModeUnusedMin = 3'd5;
  localparam mode_t       ModeUnusedMax = 3'd7;
  localparam idx_t        RegUnusedA    = 3'd6;
  localparam idx_t        RegUnusedB    = 3'd7;
  localparam logic [31:0] TimeRegMax    = 32'h00FF_FFFF;
  localparam int          RandomTicks   = 650;

  typedef struct packed {
    phase_t phase;
    logic   right;
    logic   left;
  } lamp_out_t;

  typedef struct packed {
    logic      fixed;
    lamp_out_t val;
  } preset_t;

  typedef struct packed {
    logic        is_reg;
    idx_t        idx;
    logic [31:0] value;
    logic        fixed;
    lamp_out_t   want;
  } dir_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [lbps_pkg::AddrBits-1:0] paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [7:0]                    m_axis_tdata;

  // Predictor copy of the registers and of the block state.
  mode_t                          cfg_mode;
  cfg_time_t                      cfg_half;
  cfg_time_t                      cfg_short_on;
  cfg_time_t                      cfg_short_off;
  cfg_time_t                      cfg_long_on;
  cfg_time_t                      cfg_long_off;
  logic [lbps_pkg::TimeBits-1:0]  st_elapsed;
  phase_t                         st_phase;
  logic                           st_blink;
  logic                           st_left;
  logic                           st_right;

  lamp_out_t lamp_exp_q[$];
  preset_t   preset_q[$];
  dir_row_t  dir_rows[$];
  int        ticks_sent = 0;
  int        lamps_seen = 0;
  int        mismatches = 0;

  lamp_blink_pattern_sequencer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void lamp_cfg_apply(input idx_t idx, input logic [31:0] value);
    case (idx)
      lbps_pkg::RegLampMode: begin
        cfg_mode   = value[lbps_pkg::ModeBits-1:0];
        st_elapsed = '0;
        st_blink   = 1'b0;
        st_phase   = lbps_pkg::PhaseShortOnA;
      end
      lbps_pkg::RegBlinkHalf: cfg_half      = value[lbps_pkg::CfgTimeBits-1:0];
      lbps_pkg::RegShortOn:   cfg_short_on  = value[lbps_pkg::CfgTimeBits-1:0];
      lbps_pkg::RegShortOff:  cfg_short_off = value[lbps_pkg::CfgTimeBits-1:0];
      lbps_pkg::RegLongOn:    cfg_long_on   = value[lbps_pkg::CfgTimeBits-1:0];
      lbps_pkg::RegLongOff:   cfg_long_off  = value[lbps_pkg::CfgTimeBits-1:0];
      default: ;
    endcase
  endfunction

  // Advances the predicted state by one tick and returns the lamp levels it drives.
  function automatic lamp_out_t lamp_predict(input step_t step);
    logic [lbps_pkg::TimeBits:0] sum;
    phase_t                      ph;
    cfg_time_t                   limit;
    lamp_out_t                   res;
    sum = st_elapsed;
    sum = sum + step;
    st_elapsed = sum[lbps_pkg::TimeBits] ? {lbps_pkg::TimeBits{1'b1}}
                                         : sum[lbps_pkg::TimeBits-1:0];
    case (cfg_mode) inside
      lbps_pkg::ModeReverse: begin
        st_left  = 1'b1;
        st_right = 1'b1;
      end
      lbps_pkg::ModeLeft, lbps_pkg::ModeRight: begin
        if (st_elapsed >= cfg_half) begin
          st_blink   = ~st_blink;
          st_left    = (cfg_mode == lbps_pkg::ModeLeft) ? st_blink : 1'b0;
          st_right   = (cfg_mode == lbps_pkg::ModeRight) ? st_blink : 1'b0;
          st_elapsed = '0;
        end
      end
      lbps_pkg::ModeHazard: begin
        ph = (st_phase <= lbps_pkg::PhaseLongOff) ? st_phase : lbps_pkg::PhaseShortOnA;
        // Even phases are the flashes, odd phases the gaps.
        st_left  = ~ph[0];
        st_right = ~ph[0];
        case (ph) inside
          lbps_pkg::PhaseShortOffA, lbps_pkg::PhaseShortOffB: limit = cfg_short_off;
          lbps_pkg::PhaseLongOn:                              limit = cfg_long_on;
          lbps_pkg::PhaseLongOff:                             limit = cfg_long_off;
          default:                                            limit = cfg_short_on;
        endcase
        if (st_elapsed >= limit) begin
          st_phase   = (ph == lbps_pkg::PhaseLongOff) ? lbps_pkg::PhaseShortOnA : ph + 1'b1;
          st_elapsed = '0;
        end
      end
      default: begin
        st_left  = 1'b0;
        st_right = 1'b0;
      end
    endcase
    res.left  = st_left;
    res.right = st_right;
    res.phase = st_phase;
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return lbps_pkg::ModeHazard;
    if (r < 55) return lbps_pkg::ModeLeft;
    if (r < 70) return lbps_pkg::ModeRight;
    if (r < 80) return lbps_pkg::ModeReverse;
    if (r < 90) return lbps_pkg::ModeOff;
    return mode_t'($urandom_range(ModeUnusedMin, ModeUnusedMax));
  endfunction

  // Mostly short times so that toggles and phase changes come often.
  function automatic logic [31:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 250);
    if (r < 68) return $urandom_range(251, 70000);
    if (r < 76) return 32'd0;
    if (r < 82) return 32'd1;
    if (r < 90) return TimeRegMax;
    return $urandom();
  endfunction

  function automatic step_t pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return step_t'($urandom_range(0, 120));
    if (r < 80) return '0;
    if (r < 92) return step_t'($urandom_range(0, 65535));
    return '1;
  endfunction

  task automatic row_reg(input idx_t idx, input logic [31:0] value);
    dir_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.idx = idx;
    row.value = value;
    dir_rows.push_back(row);
  endtask

  task automatic row_tick(input step_t step);
    dir_row_t row;
    row = '0;
    row.value[lbps_pkg::StepBits-1:0] = step;
    dir_rows.push_back(row);
  endtask

  task automatic row_check(input step_t step, input logic left,
                           input logic right, input phase_t phase);
    dir_row_t row;
    row = '0;
    row.value[lbps_pkg::StepBits-1:0] = step;
    row.fixed = 1'b1;
    row.want.left = left;
    row.want.right = right;
    row.want.phase = phase;
    dir_rows.push_back(row);
  endtask

  // Writes are only issued once every tick sent so far has produced its result.
  task automatic reg_write(input idx_t idx, input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (lamps_seen != ticks_sent) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    lamp_cfg_apply(idx, value);
  endtask

  // The bus is released here, so back-to-back writes keep psel high between them.
  task automatic send_tick(input step_t step, input logic fixed,
                           input lamp_out_t want, input logic no_gaps);
    int gap;
    gap = no_gaps ? 0 : idle_len();
    psel    <= 1'b0;
    penable <= 1'b0;
    preset_q.push_back({fixed, want});
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= step;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    ticks_sent++;
  endtask

  always @(posedge clk_i) begin : lamp_scoreboard
    preset_t   pre;
    lamp_out_t pred;
    lamp_out_t want;
    lamp_out_t got;
    if ((s_axis_tvalid && s_axis_tready) === 1'b1) begin
      pred = lamp_predict(s_axis_tdata);
      pre = preset_q.pop_front();
      lamp_exp_q.push_back(pre.fixed ? pre.val : pred);
    end
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      lamps_seen++;
      got = m_axis_tdata[4:0];
      if (lamp_exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected lamp transfer, tdata %h", m_axis_tdata);
      end else begin
        want = lamp_exp_q.pop_front();
        if (got.left !== want.left || got.right !== want.right ||
            got.phase !== want.phase || m_axis_tdata[7:5] !== 3'b000) begin
          mismatches++;
          if (mismatches <= 10)
            $display("lamp %0d: expected L %b R %b ph %0d, got L %b R %b ph %0d pad %0d",
                     lamps_seen, want.left, want.right, want.phase,
                     got.left, got.right, got.phase, m_axis_tdata[7:5]);
        end
      end
    end
  end

  initial begin : result_sink
    int hold;
    int stall;
    @(posedge clk_i);
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 4);
      m_axis_tready <= 1'b1;
      repeat (hold) @(posedge clk_i);
      stall = idle_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int          rand_ticks;
    int          n;
    logic        no_gaps;
    logic        sat_done;
    logic [31:0] hi;
    cfg_mode      = lbps_pkg::ModeOff;
    cfg_half      = lbps_pkg::BlinkHalfRst;
    cfg_short_on  = lbps_pkg::ShortOnRst;
    cfg_short_off = lbps_pkg::ShortOffRst;
    cfg_long_on   = lbps_pkg::LongOnRst;
    cfg_long_off  = lbps_pkg::LongOffRst;
    st_elapsed    = '0;
    st_phase      = lbps_pkg::PhaseShortOnA;
    st_blink      = 1'b0;
    st_left       = 1'b0;
    st_right      = 1'b0;
    rand_ticks    = 0;
    sat_done      = 1'b0;

    // Off after reset, then reverse and an unused mode code.
    row_check(16'd0, 1'b0, 1'b0, lbps_pkg::PhaseShortOnA);
    row_check(16'hFFFF, 1'b0, 1'b0, lbps_pkg::PhaseShortOnA);
    row_reg(lbps_pkg::RegLampMode, lbps_pkg::ModeReverse);
    row_check(16'd1, 1'b1, 1'b1, lbps_pkg::PhaseShortOnA);
    row_reg(lbps_pkg::RegLampMode, ModeUnusedMax);
    row_check(16'd12345, 1'b0, 1'b0, lbps_pkg::PhaseShortOnA);
    // A zero half period toggles on every tick.
    row_reg(lbps_pkg::RegBlinkHalf, 32'd0);
    row_reg(lbps_pkg::RegLampMode, lbps_pkg::ModeLeft);
    row_check(16'd0, 1'b1, 1'b0, lbps_pkg::PhaseShortOnA);
    row_check(16'd0, 1'b0, 1'b0, lbps_pkg::PhaseShortOnA);
    row_reg(lbps_pkg::RegBlinkHalf, 32'd3);
    row_reg(lbps_pkg::RegLampMode, lbps_pkg::ModeRight);
    row_tick(16'd2);
    row_tick(16'd1);
    // Bits above the register width are dropped.
    row_reg(lbps_pkg::RegBlinkHalf, 32'hFFFF_FFFF);
    row_tick(16'hFFFF);
    // Hazard walks through all six phases and wraps.
    row_reg(lbps_pkg::RegShortOn, 32'd1);
    row_reg(lbps_pkg::RegShortOff, 32'd2);
    row_reg(lbps_pkg::RegLongOn, 32'd1);
    row_reg(lbps_pkg::RegLongOff, 32'd65535);
    row_reg(lbps_pkg::RegLampMode, lbps_pkg::ModeHazard);
    row_tick(16'd1);
    row_tick(16'd1);
    row_tick(16'd1);
    row_tick(16'd0);
    row_tick(16'd5);
    row_tick(16'hFFFF);
    row_tick(16'd0);
    row_tick(16'd1);
    row_tick(16'hFFFF);
    row_tick(16'd0);
    // A mode change keeps the levels last driven until the first toggle.
    row_reg(lbps_pkg::RegLampMode, lbps_pkg::ModeLeft);
    row_tick(16'd7);
    row_reg(RegUnusedA, 32'hFFFF_FFFF);
    row_tick(16'd0);
    row_reg(lbps_pkg::RegLampMode, {29'h1FFF_FFFF, lbps_pkg::ModeOff});
    row_check(16'd0, 1'b0, 1'b0, lbps_pkg::PhaseShortOnA);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        reg_write(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_tick(dir_rows[i].value[lbps_pkg::StepBits-1:0], dir_rows[i].fixed,
                  dir_rows[i].want, 1'b0);
      end
    end

    while (rand_ticks < RandomTicks) begin
      if (!sat_done && rand_ticks >= 200) begin
        // Full-scale steps drive the elapsed time into saturation before the toggle.
        sat_done = 1'b1;
        reg_write(lbps_pkg::RegBlinkHalf, TimeRegMax);
        reg_write(lbps_pkg::RegLampMode, lbps_pkg::ModeLeft);
        repeat (260) begin
          send_tick('1, 1'b0, '0, 1'b0);
          rand_ticks++;
        end
      end else begin
        for (int k = lbps_pkg::RegBlinkHalf; k <= lbps_pkg::RegLongOff; k++) begin
          if ($urandom_range(0, 9) < 4) reg_write(k[lbps_pkg::RegIdxBits-1:0], pick_time());
        end
        if ($urandom_range(0, 9) == 0) begin
          reg_write($urandom_range(0, 1) ? RegUnusedA : RegUnusedB, $urandom());
        end
        if ($urandom_range(0, 4) != 0) begin
          hi = $urandom_range(0, 1) ? $urandom() : 32'd0;
          reg_write(lbps_pkg::RegLampMode, {hi[31:lbps_pkg::ModeBits], pick_mode()});
        end
        n = $urandom_range(8, 50);
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (n) begin
          send_tick(pick_step(), 1'b0, '0, no_gaps);
          rand_ticks++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (lamps_seen != ticks_sent) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && lamp_exp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
